FILE: src/sbeq_pkg.sv
// Package for the stereo biquad equaliser: register indexes, widths, state types.
// No dependencies.
package sbeq_pkg;
   localparam int SampleWidth = 24;
   localparam int CoefWidth   = 32;
   localparam int GainWidth   = 24;
   localparam int HistWidth   = 32;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 32;
   localparam int AccWidth    = 72;

   localparam logic [CsrIdxWidth-1:0] CSR_EQ_ENABLE   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PREAMP_GAIN = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_COEF_SELECT = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_COEF_VALUE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic [2:0] tap;
      logic last_tap;
   } lane_ctl_type;
endpackage

FILE: src/sbeq_stream_if.sv
// Valid/ready stream interface carrying a parameterised payload.
// Depends on nothing.
interface sbeq_stream_if #(parameter int Width = 49);
   logic valid;
   logic ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/sbeq_lane.sv
// One channel lane: preamp, serial MAC over the band cascade, output rounding.
// Depends on sbeq_pkg.
module sbeq_lane
   import sbeq_pkg::*;
#(
   parameter int BandCount = 10,
   parameter int BandWidth = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctl_type                  ctl,
   input  logic [BandWidth-1:0]          band,
   input  logic signed [SampleWidth-1:0] sample,
   input  logic [GainWidth-1:0]          gain,
   input  logic signed [CoefWidth-1:0]   coef,
   output logic signed [SampleWidth-1:0] result
);
   logic signed [HistWidth-1:0] hx1_ff [BandCount];
   logic signed [HistWidth-1:0] hx2_ff [BandCount];
   logic signed [HistWidth-1:0] hy1_ff [BandCount];
   logic signed [HistWidth-1:0] hy2_ff [BandCount];
   logic signed [HistWidth-1:0] x_ff, x_in;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic signed [HistWidth-1:0] op;
   logic signed [63:0]          prod;
   logic signed [AccWidth-1:0]  sum;
   logic signed [AccWidth-1:0]  rnd;
   logic signed [HistWidth-1:0] y;
   logic signed [49:0]          pre;
   logic signed [HistWidth-1:0] pre_sat;
   logic signed [HistWidth:0]   out_r;

   always_comb begin
      pre = (50'(sample) * $signed({1'b0, gain}) + 50'sd262144) >>> 19;
      if (pre > 50'sd2147483647) pre_sat = 32'sh7fffffff;
      else if (pre < -50'sd2147483648) pre_sat = 32'sh80000000;
      else pre_sat = pre[HistWidth-1:0];
   end

   always_comb begin
      case (ctl.tap)
         3'd0: op = x_ff;
         3'd1: op = hx1_ff[band];
         3'd2: op = hx2_ff[band];
         3'd3: op = hy1_ff[band];
         default: op = hy2_ff[band];
      endcase
      prod = 64'(coef) * 64'(op);
      if (ctl.tap >= 3'd3) sum = acc_ff - AccWidth'(prod);
      else sum = acc_ff + AccWidth'(prod);
      rnd = (sum + AccWidth'(64'sd536870912)) >>> 30;
      if (rnd > 72'sd2147483647) y = 32'sh7fffffff;
      else if (rnd < -72'sd2147483648) y = 32'sh80000000;
      else y = rnd[HistWidth-1:0];
   end

   always_comb begin
      x_in   = x_ff;
      acc_in = ctl.tap == 3'd0 ? AccWidth'(prod) : sum;
      if (ctl.start) x_in = pre_sat;
      else if (ctl.last_tap) x_in = y;
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
      if (reset || ctl.clear) begin
         for (int i = 0; i < BandCount; i++) begin
            hx1_ff[i] <= '0;
            hx2_ff[i] <= '0;
            hy1_ff[i] <= '0;
            hy2_ff[i] <= '0;
         end
      end else if (ctl.last_tap) begin
         hx2_ff[band] <= hx1_ff[band];
         hx1_ff[band] <= x_ff;
         hy2_ff[band] <= hy1_ff[band];
         hy1_ff[band] <= y;
      end
   end

   always_comb begin
      out_r = ($signed({x_ff[HistWidth-1], x_ff}) + 33'sd1) >>> 1;
      if (out_r > 33'sd8388607) result = 24'sh7fffff;
      else if (out_r < -33'sd8388608) result = 24'sh800000;
      else result = out_r[SampleWidth-1:0];
   end
endmodule

FILE: src/stereo_biquad_eq_cascade.sv
// Stereo EQ top level: CSRs, coefficient memory, sequencer, two lanes, output register.
// Depends on sbeq_pkg, sbeq_stream_if and sbeq_lane.
// An enabled frame passes from acceptance through the preamp, run and done states, and its
// result is written to the output register in the done state; each lane has one 32x32
// multiplier stepping through five taps per band, reading one coefficient a cycle from the
// shared memory. A disabled frame goes from acceptance straight to the done state. A frame is
// accepted only while the lanes are idle and the output register is empty or being read in
// the same cycle.
module stereo_biquad_eq_cascade
   import sbeq_pkg::*;
#(
   parameter int BAND_COUNT = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   sbeq_stream_if.sink            req,
   sbeq_stream_if.source          rsp,
   input  logic                   csr_write,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_data
);
   localparam int SlotCount = BAND_COUNT * 5;
   localparam int SlotWidth = $clog2(SlotCount + 1) < 6 ? 6 : $clog2(SlotCount + 1);
   localparam int BandWidth = $clog2(BAND_COUNT) < 1 ? 1 : $clog2(BAND_COUNT);

   logic                  enable_ff;
   logic [GainWidth-1:0]  gain_ff;
   logic [5:0]            select_ff;
   logic signed [CoefWidth-1:0] coef_mem [SlotCount];
   logic signed [CoefWidth-1:0] coef_rd_ff;
   logic [SlotCount-1:0]  slot_written_ff;
   logic                  slot_valid_ff;

   state_type state_ff, state_in;
   logic [BandWidth-1:0] band_ff, band_in;
   logic [2:0]           tap_ff, tap_in;
   logic signed [SampleWidth-1:0] left_ff, right_ff;
   logic                 pass_ff;
   logic                 full_ff, full_in;
   logic [2*SampleWidth-1:0] out_ff;
   lane_ctl_type         ctl;
   logic signed [CoefWidth-1:0] coef;
   logic signed [SampleWidth-1:0] left_res, right_res;
   logic                 accept, done;
   logic [SlotWidth-1:0] slot_addr;

   assign accept = req.valid && req.ready;
   assign req.ready = state_ff == ST_IDLE && (!full_ff || rsp.ready);
   assign rsp.valid = full_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         gain_ff         <= GainWidth'(1048576);
         select_ff       <= '0;
         slot_written_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EQ_ENABLE:   enable_ff <= csr_data[0];
            CSR_PREAMP_GAIN: gain_ff   <= csr_data[GainWidth-1:0];
            CSR_COEF_SELECT: select_ff <= csr_data[5:0];
            CSR_COEF_VALUE: begin
               if (32'(select_ff) < 32'(SlotCount))
                  slot_written_ff[select_ff] <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (csr_write && csr_index == CSR_COEF_VALUE && 32'(select_ff) < 32'(SlotCount))
         coef_mem[select_ff[SlotWidth-1:0]] <= csr_data;
      coef_rd_ff    <= coef_mem[slot_addr];
      slot_valid_ff <= slot_written_ff[slot_addr];
   end

   assign slot_addr = SlotWidth'(32'(band_in) * 5 + 32'(tap_in));
   assign coef = slot_valid_ff ? coef_rd_ff
               : (tap_ff == 3'd0 ? 32'sh40000000 : '0);

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            band_in = '0;
            tap_in  = '0;
            if (accept) state_in = enable_ff ? ST_PRE : ST_DONE;
         end
         ST_PRE: state_in = ST_RUN;
         ST_RUN: begin
            if (tap_ff == 3'd4) begin
               tap_in = '0;
               if (32'(band_ff) == BAND_COUNT - 1) state_in = ST_DONE;
               else band_in = band_ff + 1'b1;
            end else tap_in = tap_ff + 3'd1;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.start    = state_ff == ST_PRE;
      ctl.clear    = accept && (!enable_ff || req.data[2*SampleWidth]);
      ctl.tap      = tap_ff;
      ctl.last_tap = state_ff == ST_RUN && tap_ff == 3'd4;
      done         = state_ff == ST_DONE;
   end

   always_comb begin
      full_in = full_ff;
      if (rsp.ready) full_in = 1'b0;
      if (done) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         band_ff  <= '0;
         tap_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         tap_ff   <= tap_in;
         full_ff  <= full_in;
      end
      if (accept) begin
         left_ff  <= req.data[SampleWidth-1:0];
         right_ff <= req.data[2*SampleWidth-1:SampleWidth];
         pass_ff  <= !enable_ff;
      end
      if (done)
         out_ff <= pass_ff ? {right_ff, left_ff} : {right_res, left_res};
   end

   sbeq_lane #(.BandCount(BAND_COUNT), .BandWidth(BandWidth)) u_left (
      .clock, .reset, .ctl, .band(band_ff), .sample(left_ff), .gain(gain_ff), .coef,
      .result(left_res)
   );

   sbeq_lane #(.BandCount(BAND_COUNT), .BandWidth(BandWidth)) u_right (
      .clock, .reset, .ctl, .band(band_ff), .sample(right_ff), .gain(gain_ff), .coef,
      .result(right_res)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept) else $error("beat taken while busy");
   a_done_fills: assert property (@(posedge clock) disable iff (reset)
      done |=> full_ff) else $error("result lost");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= 3'd4) else $error("tap out of range");
endmodule

FILE: test/stereo_biquad_eq_cascade_test.sv
// Self-checking bench for the stereo biquad equaliser: drives frames and register writes,
// predicts each result with a bit-true preamp/biquad/saturation model and checks every beat.
// Depends on sbeq_pkg, sbeq_stream_if and stereo_biquad_eq_cascade.
module stereo_biquad_eq_cascade_test
   import sbeq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Bands     = 10;
   localparam int Slots     = Bands * 5;
   localparam int CycleCap  = 1500000;
   localparam logic signed [31:0] QOne = 32'sh4000_0000;

   typedef struct packed {
      logic restart;
      logic signed [SampleWidth-1:0] right;
      logic signed [SampleWidth-1:0] left;
   } frame_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] right;
      logic signed [SampleWidth-1:0] left;
   } stereo_out_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrDatWidth-1:0] csr_data;

   sbeq_stream_if #(.Width(49)) req_if ();
   sbeq_stream_if #(.Width(48)) rsp_if ();

   stereo_biquad_eq_cascade #(.BAND_COUNT(Bands)) dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   logic eq_on;
   logic [GainWidth-1:0] gain_q420;
   logic [5:0] coef_slot;
   logic signed [31:0] coef_mem [Slots];
   logic signed [31:0] filt_hist [2][Bands][4];

   frame_type pending_frames [$];
   stereo_out_type expected_frames [$];
   int send_idle_pct, recv_stall_pct;
   int frames_sent, frames_checked, mismatches, cycles;

   function automatic logic signed [79:0] clamp(logic signed [79:0] v,
                                                logic signed [79:0] lo,
                                                logic signed [79:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [SampleWidth-1:0] equalise_lane(int ch,
                                                  logic signed [SampleWidth-1:0] s);
      logic signed [79:0] v, acc, x, c0, c1, c2, c3, c4, h0, h1, h2, h3;
      logic signed [79:0] lo32, hi32;
      lo32 = -80'sd2147483648;
      hi32 = 80'sd2147483647;
      v = s;
      v = (v * $signed({56'd0, gain_q420}) + 80'sd262144) >>> 19;
      v = clamp(v, lo32, hi32);
      for (int b = 0; b < Bands; b++) begin
         x = v;
         c0 = coef_mem[b*5];   c1 = coef_mem[b*5+1]; c2 = coef_mem[b*5+2];
         c3 = coef_mem[b*5+3]; c4 = coef_mem[b*5+4];
         h0 = filt_hist[ch][b][0]; h1 = filt_hist[ch][b][1];
         h2 = filt_hist[ch][b][2]; h3 = filt_hist[ch][b][3];
         acc = c0*x + c1*h0 + c2*h1 - c3*h2 - c4*h3;
         v = clamp((acc + 80'sd536870912) >>> 30, lo32, hi32);
         filt_hist[ch][b][1] = filt_hist[ch][b][0];
         filt_hist[ch][b][0] = x[31:0];
         filt_hist[ch][b][3] = filt_hist[ch][b][2];
         filt_hist[ch][b][2] = v[31:0];
      end
      v = clamp((v + 80'sd1) >>> 1, -80'sd8388608, 80'sd8388607);
      return v[SampleWidth-1:0];
   endfunction

   function automatic stereo_out_type equalise_frame(frame_type f);
      stereo_out_type r;
      if (f.restart || !eq_on)
         foreach (filt_hist[c, b, k]) filt_hist[c][b][k] = '0;
      if (!eq_on) begin
         r.left = f.left;
         r.right = f.right;
      end else begin
         r.left = equalise_lane(0, f.left);
         r.right = equalise_lane(1, f.right);
      end
      return r;
   endfunction

   task automatic csr_put(logic [CsrIdxWidth-1:0] idx, logic [CsrDatWidth-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_EQ_ENABLE:   eq_on = val[0];
         CSR_PREAMP_GAIN: gain_q420 = val[GainWidth-1:0];
         CSR_COEF_SELECT: coef_slot = val[5:0];
         CSR_COEF_VALUE:  if (coef_slot < Slots) coef_mem[coef_slot] = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic coef_put(int slot, logic [31:0] val);
      csr_put(CSR_COEF_SELECT, slot);
      csr_put(CSR_COEF_VALUE, val);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_frames.size() != 0 || req_if.valid || expected_frames.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic signed [23:0] pick_sample();
      case ($urandom_range(15))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'sh000000;
         3: return 24'shFFFFFF;
         4, 5, 6: return $signed(24'($urandom_range(4095))) - 24'sd2048;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic queue_frame(logic signed [23:0] l, logic signed [23:0] r, logic rs);
      frame_type f;
      f.left = l;
      f.right = r;
      f.restart = rs;
      pending_frames.push_back(f);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                  expected_frames.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_frames.push_back(equalise_frame(frame_type'(req_if.data)));
            frames_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.data <= pending_frames.pop_front();
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      stereo_out_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (expected_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: left %h right %h", got.left, got.right);
            end else begin
               want = expected_frames.pop_front();
               frames_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d: left exp %h got %h, right exp %h got %h",
                              frames_checked, want.left, got.left, want.right, got.right);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int phases;
      bit wild;
      phases = 0;
      frames_sent = 0;
      frames_checked = 0;
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      eq_on = 1'b0;
      gain_q420 = 24'h100000;
      coef_slot = '0;
      for (int i = 0; i < Slots; i++) coef_mem[i] = (i % 5 == 0) ? QOne : 32'sd0;
      foreach (filt_hist[c, b, k]) filt_hist[c][b][k] = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // pass-through, restart while disabled
      queue_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
      queue_frame(24'sh000000, 24'shFFFFFF, 1'b1);
      queue_frame(24'sh123456, 24'shABCDEF, 1'b0);
      drain();

      // unity cascade at reset coefficients, then preamp extremes
      csr_put(CSR_EQ_ENABLE, 1);
      queue_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
      queue_frame(24'shFFFFFF, 24'sh000001, 1'b0);
      queue_frame(24'sh000000, 24'sh400000, 1'b1);
      drain();
      csr_put(CSR_PREAMP_GAIN, 24'hFFFFFF);
      queue_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
      queue_frame(24'sh000100, 24'shFFFF00, 1'b0);
      drain();
      csr_put(CSR_PREAMP_GAIN, 0);
      queue_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
      drain();

      // last slot, coefficient extremes, writes to slots beyond the store
      csr_put(CSR_PREAMP_GAIN, 24'h100000);
      coef_put(45, 32'h7FFFFFFF);
      coef_put(46, 32'h80000000);
      coef_put(48, 32'h20000000);
      coef_put(49, 32'hC0000000);
      coef_put(Slots, 32'h7FFFFFFF);
      coef_put(63, 32'h80000000);
      for (int i = 0; i < 8; i++) queue_frame(pick_sample(), pick_sample(), i == 5);
      drain();
      csr_put(CSR_EQ_ENABLE, 0);
      queue_frame(24'sh654321, 24'sh800000, 1'b1);
      drain();

      for (int p = 0; p < 28; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         wild = ($urandom_range(3) == 0);
         for (int s = 0; s < Slots; s++) begin
            if (p % 3 == 0 || $urandom_range(3) == 0) begin
               if (wild)
                  coef_put(s, $urandom);
               else if (s % 5 == 0)
                  coef_put(s, QOne + $signed($urandom_range(1 << 28)) - (1 << 27));
               else
                  coef_put(s, $signed($urandom_range(1 << 28)) - (1 << 27));
            end
         end
         if ($urandom_range(3) == 0) coef_put($urandom_range(63, Slots), $urandom);
         case ($urandom_range(7))
            0: csr_put(CSR_PREAMP_GAIN, 0);
            1: csr_put(CSR_PREAMP_GAIN, 24'hFFFFFF);
            default: csr_put(CSR_PREAMP_GAIN, $urandom_range(24'h200000, 24'h040000));
         endcase
         csr_put(CSR_EQ_ENABLE, $urandom_range(6) != 0);
         for (int i = 0; i < 50; i++)
            queue_frame(pick_sample(), pick_sample(), $urandom_range(19) == 0);
         drain();
         phases++;
      end

      repeat (60) @(negedge clock);
      $display("%0d frames sent, %0d results checked over %0d random register settings",
               frames_sent, frames_checked, phases);
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_frames.size());
      if (mismatches == 0 && expected_frames.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
